@@ sv/nnsb_pkg.sv @@
// ----------------------------------------------------------------------------
// nnsb_pkg
// shared types and constants of the nearest-neighbor stretch blitter
// ----------------------------------------------------------------------------
package nnsb_pkg;

  localparam int ADDR_W     = 16;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DST_W  = 3'd2,
    REG_DST_H  = 3'd3,
    REG_KEY_EN = 3'd4
  } cfg_reg_t;

  // effective (clamped) rectangle sizes
  typedef struct packed {
    logic [8:0]  src_w;
    logic [8:0]  src_h;
    logic [11:0] dst_w;
    logic [11:0] dst_h;
  } size_t;

  // one result beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             write_enable;
    logic [10:0]      dest_x;
    logic [10:0]      dest_y;
    logic             row_end;
    logic             frame_end;
  } beat_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_READ    = 4'b0010,
    ST_ADV_COL = 4'b0100,
    ST_ADV_ROW = 4'b1000
  } walk_state_t;

endpackage

@@ sv/nnsb_ram.sv @@
// ----------------------------------------------------------------------------
// nnsb_ram
// generic single-port ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module nnsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/nnsb_load_addr.sv @@
// ----------------------------------------------------------------------------
// nnsb_load_addr
// raster write address for source pixel loads, wraps at the rectangle end
// ----------------------------------------------------------------------------
module nnsb_load_addr
  import nnsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_fire,
  input  size_t             sizes,
  output logic [ADDR_W-1:0] load_addr
);

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic              col_last, row_last;

  assign col_last = {1'b0, col_r} >= (sizes.src_w - 9'd1);
  assign row_last = {1'b0, row_r} >= (sizes.src_h - 9'd1);

  always_comb begin
    addr_nxt = addr_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (load_fire) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          addr_nxt = '0;
        end else begin
          row_nxt  = row_r + 8'd1;
          addr_nxt = addr_r + 16'd1;
        end
      end else begin
        col_nxt  = col_r + 8'd1;
        addr_nxt = addr_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      addr_r <= addr_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  assign load_addr = addr_r;

endmodule

@@ sv/nnsb_walk.sv @@
// ----------------------------------------------------------------------------
// nnsb_walk
// destination raster walker: source pick, result beat, accumulator stepping
// ----------------------------------------------------------------------------
module nnsb_walk
  import nnsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_fire,
  input  size_t             sizes,
  input  logic              key_en,
  input  logic [PIX_W-1:0]  rd_data,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              busy,
  output logic              out_valid,
  output beat_t             out_beat
);

  walk_state_t       state_r, state_nxt;
  logic [10:0]       out_col_r, out_col_nxt;
  logic [10:0]       out_row_r, out_row_nxt;
  logic [12:0]       col_acc_r, col_acc_nxt;
  logic [12:0]       row_acc_r, row_acc_nxt;
  logic [7:0]        src_col_r, src_col_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic              out_valid_r, out_valid_nxt;
  beat_t             beat_r, beat_nxt;

  logic last_col, last_row, col_ge, row_ge;

  assign last_col = {1'b0, out_col_r} >= (sizes.dst_w - 12'd1);
  assign last_row = {1'b0, out_row_r} >= (sizes.dst_h - 12'd1);
  assign col_ge   = col_acc_r >= {1'b0, sizes.dst_w};
  assign row_ge   = row_acc_r >= {1'b0, sizes.dst_h};
  assign rd_addr  = row_base_r + {8'd0, src_col_r};

  always_comb begin
    state_nxt     = state_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    col_acc_nxt   = col_acc_r;
    row_acc_nxt   = row_acc_r;
    src_col_nxt   = src_col_r;
    row_base_nxt  = row_base_r;
    out_valid_nxt = 1'b0;
    beat_nxt      = beat_r;
    case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_nxt         = 1'b1;
        beat_nxt.pixel        = rd_data;
        beat_nxt.write_enable = !(key_en && (rd_data == '0));
        beat_nxt.dest_x       = out_col_r;
        beat_nxt.dest_y       = out_row_r;
        beat_nxt.row_end      = last_col;
        beat_nxt.frame_end    = last_col && last_row;
        if (!last_col) begin
          col_acc_nxt = col_acc_r + {4'd0, sizes.src_w};
          out_col_nxt = out_col_r + 11'd1;
          state_nxt   = ST_ADV_COL;
        end else begin
          out_col_nxt = '0;
          col_acc_nxt = '0;
          src_col_nxt = '0;
          if (last_row) begin
            out_row_nxt  = '0;
            row_acc_nxt  = '0;
            row_base_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            row_acc_nxt = row_acc_r + {4'd0, sizes.src_h};
            out_row_nxt = out_row_r + 11'd1;
            state_nxt   = ST_ADV_ROW;
          end
        end
      end
      ST_ADV_COL: begin
        if (col_ge) begin
          col_acc_nxt = col_acc_r - {1'b0, sizes.dst_w};
          src_col_nxt = src_col_r + 8'd1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADV_ROW: begin
        if (row_ge) begin
          row_acc_nxt  = row_acc_r - {1'b0, sizes.dst_h};
          row_base_nxt = row_base_r + {7'd0, sizes.src_w};
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_col_r   <= '0;
      out_row_r   <= '0;
      col_acc_r   <= '0;
      row_acc_r   <= '0;
      src_col_r   <= '0;
      row_base_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      col_acc_r   <= col_acc_nxt;
      row_acc_r   <= row_acc_nxt;
      src_col_r   <= src_col_nxt;
      row_base_r  <= row_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

  // a strobe only follows the read cycle
  a_valid_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_READ))
    else $error("result strobe without a preceding read");

  // never two strobes in a row for one request
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // column stepping stops once the accumulator is below the target width
  a_col_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADV_COL && !col_ge) |=> state_r == ST_IDLE)
    else $error("column advance did not finish");

  // end of frame is always also end of row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && beat_r.frame_end) |-> beat_r.row_end)
    else $error("frame end without row end");

endmodule

@@ sv/nearest_neighbor_stretch_blit_core.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_stretch_blit_core
// 16-bit nearest-neighbor stretcher around one source pixel ram
// ----------------------------------------------------------------------------
//
// channel   ports                                   handshake
// --------  --------------------------------------  ------------------------------
// input     in_mode, in_pixel_in                    start high while busy low
// result    out_pixel_out .. out_frame_end          out_valid strobe, one cycle
// config    cfg_index, cfg_wdata                    cfg_we high, taken at once
//
// - a load beat: the pixel is written to the ram at the accept edge and busy
//   stays low
// - a request beat keeps busy high through the read state and the column (or
//   row) advance state, which repeats the accumulator subtract per source
//   column (or row) skipped; at end of frame the read state returns to idle
// - the result strobe is registered out of the read state and may come while
//   the walker is still stepping its accumulators
// - synchronous active-low reset clears all counters and sets the sizes to 1;
//   the ram has no reset, unwritten entries read as garbage
// - results cannot be stalled, so no output buffering beyond one register
//
module nearest_neighbor_stretch_blit_core
  import nnsb_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_SIZE   = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [PIX_W-1:0]      in_pixel_in,
  // result beats
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_write_enable,
  output logic [10:0]           out_dest_x,
  output logic [10:0]           out_dest_y,
  output logic                  out_row_end,
  output logic                  out_frame_end,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // size limits, capped at what the register fields can hold
  localparam int SW_LIM_I = (MAX_SRC_WIDTH  > 511)  ? 511  : MAX_SRC_WIDTH;
  localparam int SH_LIM_I = (MAX_SRC_HEIGHT > 511)  ? 511  : MAX_SRC_HEIGHT;
  localparam int DS_LIM_I = (MAX_DST_SIZE   > 4095) ? 4095 : MAX_DST_SIZE;
  localparam logic [8:0]  SW_LIM = 9'(SW_LIM_I);
  localparam logic [8:0]  SH_LIM = 9'(SH_LIM_I);
  localparam logic [11:0] DS_LIM = 12'(DS_LIM_I);

  // raw configuration registers
  logic [8:0]  src_w_r, src_h_r;
  logic [11:0] dst_w_r, dst_h_r;
  logic        key_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= 9'd1;
      src_h_r  <= 9'd1;
      dst_w_r  <= 12'd1;
      dst_h_r  <= 12'd1;
      key_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W:  src_w_r  <= cfg_wdata[8:0];
        REG_SRC_H:  src_h_r  <= cfg_wdata[8:0];
        REG_DST_W:  dst_w_r  <= cfg_wdata;
        REG_DST_H:  dst_h_r  <= cfg_wdata;
        REG_KEY_EN: key_en_r <= cfg_wdata[0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // zero acts as one, anything above the limit saturates
  size_t sizes;

  always_comb begin
    sizes.src_w = (src_w_r == '0) ? 9'd1  : ((src_w_r > SW_LIM) ? SW_LIM : src_w_r);
    sizes.src_h = (src_h_r == '0) ? 9'd1  : ((src_h_r > SH_LIM) ? SH_LIM : src_h_r);
    sizes.dst_w = (dst_w_r == '0) ? 12'd1 : ((dst_w_r > DS_LIM) ? DS_LIM : dst_w_r);
    sizes.dst_h = (dst_h_r == '0) ? 12'd1 : ((dst_h_r > DS_LIM) ? DS_LIM : dst_h_r);
  end

  // accept decode
  logic accept, load_fire, req_fire;

  assign accept    = start && !busy;
  assign load_fire = accept && !in_mode;
  assign req_fire  = accept && in_mode;

  // load address generator
  logic [ADDR_W-1:0] load_addr;

  nnsb_load_addr u_load_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_fire (load_fire),
    .sizes     (sizes),
    .load_addr (load_addr)
  );

  // source pixel store: loads write, requests read at the same port
  logic [ADDR_W-1:0] rd_addr, ram_addr;
  logic [PIX_W-1:0]  rd_data;

  assign ram_addr = load_fire ? load_addr : rd_addr;

  nnsb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (1 << ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (load_fire),
    .addr  (ram_addr),
    .wdata (in_pixel_in),
    .rdata (rd_data)
  );

  // destination walker, owns busy and the result register
  beat_t beat;

  nnsb_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .sizes     (sizes),
    .key_en    (key_en_r),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .busy      (busy),
    .out_valid (out_valid),
    .out_beat  (beat)
  );

  assign out_pixel_out    = beat.pixel;
  assign out_write_enable = beat.write_enable;
  assign out_dest_x       = beat.dest_x;
  assign out_dest_y       = beat.dest_y;
  assign out_row_end      = beat.row_end;
  assign out_frame_end    = beat.frame_end;

endmodule
